// ----- hdl/lfps_pkg.sv -----
`default_nettype none
package lfps_pkg;

  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned POS_W     = 11;
  localparam int unsigned ERR_W     = 12;
  localparam int unsigned DERR_W    = 13;
  localparam int unsigned SUM_W     = 24;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned OPB_W     = 25;
  localparam int unsigned ACC_W     = 42;
  localparam int unsigned CTRL_W    = 10;
  localparam int unsigned NUM_SENS  = 5;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KP        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KI        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KD        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED = 3'd5;

  // register reset values
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 10'd800;
  localparam logic [POS_W-1:0]    TARGET_RST    = 11'd768;
  localparam logic [GAIN_W-1:0]   KP_RST        = 16'd51200;
  localparam logic [GAIN_W-1:0]   KI_RST        = 16'd51;
  localparam logic [GAIN_W-1:0]   KD_RST        = 16'd30720;
  localparam logic [7:0]          TOP_SPEED_RST = 8'd200;
  localparam logic [POS_W-1:0]    CENTER_POS    = 11'd768;

  // motor direction codes
  localparam logic [1:0] DIR_CW  = 2'd1;
  localparam logic [1:0] DIR_CCW = 2'd2;

  localparam logic [7:0]        FULL_SPEED  = 8'd255;
  localparam logic [8:0]        CTRL_LIMIT  = 9'd510;
  localparam logic [ACC_W-1:0]  LIMIT_Q16   = 42'd33423360;  // 510 << 16
  localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sh7FFFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 24'sh800000;

  // reciprocals for position divide by 3 and by 5
  localparam logic [16:0] RECIP3 = 17'd43691;  // ceil(2^17/3)
  localparam logic [17:0] RECIP5 = 18'd52429;  // ceil(2^18/5)

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POS,
    S_ERR,
    S_P,
    S_I,
    S_D,
    S_CLAMP,
    S_MAP,
    S_DUTY_L,
    S_DUTY_R,
    S_OUT
  } state_t;

  typedef struct packed {
    logic en;
    logic clear;
  } mac_ctrl_t;

  // floor(x / 255), exact for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/lfps_position.sv -----
`default_nettype none
module lfps_position (
  input  wire lfps_pkg::sample_t             samples [lfps_pkg::NUM_SENS],
  input  wire logic [lfps_pkg::SAMPLE_W-1:0] threshold,
  output logic                               found,
  output logic [lfps_pkg::POS_W-1:0]         position
);

  logic [2:0]  count;
  logic [3:0]  wsum;
  logic [11:0] scaled;
  logic [28:0] prod3;
  logic [29:0] prod5;

  always_comb begin
    count = 3'd0;
    wsum  = 4'd0;
    for (int i = 0; i < lfps_pkg::NUM_SENS; i++) begin
      if (samples[i] > threshold) begin
        count = count + 3'd1;
        wsum  = wsum + 4'(i + 1);
      end
    end
  end

  assign scaled = {wsum, 8'd0};
  assign prod3  = {17'd0, scaled} * {12'd0, lfps_pkg::RECIP3};
  assign prod5  = {18'd0, scaled} * {12'd0, lfps_pkg::RECIP5};
  assign found  = (count != 3'd0);

  always_comb begin
    unique case (count)
      3'd1:    position = scaled[10:0];
      3'd2:    position = scaled[11:1];
      3'd3:    position = prod3[27:17];
      3'd4:    position = {1'b0, scaled[11:2]};
      3'd5:    position = prod5[28:18];
      default: position = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/lfps_mac.sv -----
`default_nettype none
module lfps_mac (
  input  wire                                    clk,
  input  wire lfps_pkg::mac_ctrl_t               ctrl,
  input  wire logic [lfps_pkg::GAIN_W-1:0]       op_a,
  input  wire logic signed [lfps_pkg::OPB_W-1:0] op_b,
  output logic signed [lfps_pkg::ACC_W-1:0]      acc
);

  logic signed [lfps_pkg::ACC_W-1:0] product;

  assign product = $signed({1'b0, op_a}) * op_b;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc <= ctrl.clear ? product : acc + product;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/line_follow_pid_steering_unit.sv -----
`default_nettype none
// Line follower steering: five reflectance samples in, motor commands out.
// Input transfer on s_axis: tdata carries sample_one..sample_five, 10 bits
// each, sample_one in the lowest bits. One result transfer on m_axis per
// input transfer, in order.
// Registers are written over the cfg channel (cfg_index, cfg_data); cfg_ready
// is always high. Write them only while the block is idle.
// Each item walks a sequencer through position, error, three multiply-
// accumulate steps (P, I, D), clamp, motor mapping and two duty multiplies;
// the multiplies all share one 16x25 multiply-accumulate unit.
// s_axis_tready is high only in the idle state, so a new item is not
// accepted until the last one has left its final step.
// A finished result sits in the output register; the next item is accepted
// and computed meanwhile and waits in its last step until that register is
// taken, so a stalled receiver holds the input side off after one item.
// Reset (rst, synchronous) restores register defaults, clears the integral
// and previous error, sets the last position to center (3.0) and empties
// the output register.
module line_follow_pid_steering_unit (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  // sample_one, sample_two, sample_three, sample_four, sample_five, pad
  input  wire logic [lfps_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // left_direction, left_duty, right_direction, right_duty, line_found,
  // position_used, steering_value, pad
  output logic [lfps_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lfps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lfps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // configuration
  logic [lfps_pkg::SAMPLE_W-1:0] threshold;
  logic [lfps_pkg::POS_W-1:0]    target;
  logic [lfps_pkg::GAIN_W-1:0]   kp, ki, kd;
  logic [7:0]                    top_speed;

  lfps_pkg::state_t state, state_next;
  lfps_pkg::sample_t samples [lfps_pkg::NUM_SENS];

  logic                              pos_found;
  logic [lfps_pkg::POS_W-1:0]        pos_calc;
  logic                              found;
  logic [lfps_pkg::POS_W-1:0]        position;
  logic [lfps_pkg::POS_W-1:0]        last_position;
  logic signed [lfps_pkg::ERR_W-1:0] err;
  logic signed [lfps_pkg::ERR_W-1:0] last_error;
  logic signed [lfps_pkg::SUM_W-1:0] error_sum;
  logic signed [lfps_pkg::DERR_W-1:0] derr;
  logic signed [lfps_pkg::SUM_W:0]   sum_wide;
  logic signed [lfps_pkg::SUM_W-1:0] sum_sat;

  lfps_pkg::mac_ctrl_t               mac_ctrl;
  logic [lfps_pkg::GAIN_W-1:0]       mac_a;
  logic signed [lfps_pkg::OPB_W-1:0] mac_b;
  logic signed [lfps_pkg::ACC_W-1:0] acc;

  logic                              acc_neg;
  logic [lfps_pkg::ACC_W-1:0]        acc_mag;
  logic [8:0]                        ctrl_mag;
  logic signed [lfps_pkg::CTRL_W-1:0] ctrl_next;
  logic signed [lfps_pkg::CTRL_W-1:0] ctrl_val;

  logic [1:0] ldir, rdir, ldir_next, rdir_next;
  logic [7:0] lspd, rspd, lspd_next, rspd_next;
  logic [7:0] lduty;
  logic [7:0] rduty;
  logic       out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= lfps_pkg::THRESHOLD_RST;
      target    <= lfps_pkg::TARGET_RST;
      kp        <= lfps_pkg::KP_RST;
      ki        <= lfps_pkg::KI_RST;
      kd        <= lfps_pkg::KD_RST;
      top_speed <= lfps_pkg::TOP_SPEED_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lfps_pkg::REG_THRESHOLD: threshold <= cfg_data[lfps_pkg::SAMPLE_W-1:0];
        lfps_pkg::REG_TARGET:    target    <= cfg_data[lfps_pkg::POS_W-1:0];
        lfps_pkg::REG_KP:        kp        <= cfg_data;
        lfps_pkg::REG_KI:        ki        <= cfg_data;
        lfps_pkg::REG_KD:        kd        <= cfg_data;
        lfps_pkg::REG_TOP_SPEED: top_speed <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  lfps_position u_position (
    .samples   (samples),
    .threshold (threshold),
    .found     (pos_found),
    .position  (pos_calc)
  );

  lfps_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (acc)
  );

  assign out_free = !m_axis_tvalid || m_axis_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lfps_pkg::S_IDLE:   if (s_axis_tvalid) state_next = lfps_pkg::S_POS;
      lfps_pkg::S_POS:    state_next = lfps_pkg::S_ERR;
      lfps_pkg::S_ERR:    state_next = lfps_pkg::S_P;
      lfps_pkg::S_P:      state_next = lfps_pkg::S_I;
      lfps_pkg::S_I:      state_next = lfps_pkg::S_D;
      lfps_pkg::S_D:      state_next = lfps_pkg::S_CLAMP;
      lfps_pkg::S_CLAMP:  state_next = lfps_pkg::S_MAP;
      lfps_pkg::S_MAP:    state_next = lfps_pkg::S_DUTY_L;
      lfps_pkg::S_DUTY_L: state_next = lfps_pkg::S_DUTY_R;
      lfps_pkg::S_DUTY_R: state_next = lfps_pkg::S_OUT;
      lfps_pkg::S_OUT:    if (out_free) state_next = lfps_pkg::S_IDLE;
      default:            state_next = lfps_pkg::S_IDLE;
    endcase
  end

  function automatic logic signed [lfps_pkg::DERR_W-1:0] DERR_EXT(
      input logic signed [lfps_pkg::ERR_W-1:0] v);
    return {v[lfps_pkg::ERR_W-1], v};
  endfunction

  assign derr = DERR_EXT(err) - DERR_EXT(last_error);

  // outputs of the sequencer: handshake and shared unit operands
  always_comb begin
    s_axis_tready = 1'b0;
    mac_ctrl      = '{en: 1'b0, clear: 1'b0};
    mac_a         = '0;
    mac_b         = '0;
    unique case (state)
      lfps_pkg::S_IDLE: s_axis_tready = 1'b1;
      lfps_pkg::S_P: begin
        mac_ctrl = '{en: 1'b1, clear: 1'b1};
        mac_a    = kp;
        mac_b    = {{(lfps_pkg::OPB_W-lfps_pkg::ERR_W){err[lfps_pkg::ERR_W-1]}}, err};
      end
      lfps_pkg::S_I: begin
        mac_ctrl = '{en: 1'b1, clear: 1'b0};
        mac_a    = ki;
        mac_b    = {error_sum[lfps_pkg::SUM_W-1], error_sum};
      end
      lfps_pkg::S_D: begin
        mac_ctrl = '{en: 1'b1, clear: 1'b0};
        mac_a    = kd;
        mac_b    = {{(lfps_pkg::OPB_W-lfps_pkg::DERR_W){derr[lfps_pkg::DERR_W-1]}}, derr};
      end
      lfps_pkg::S_DUTY_L: begin
        mac_ctrl = '{en: 1'b1, clear: 1'b1};
        mac_a    = {8'd0, top_speed};
        mac_b    = {17'd0, lspd};
      end
      lfps_pkg::S_DUTY_R: begin
        mac_ctrl = '{en: 1'b1, clear: 1'b1};
        mac_a    = {8'd0, top_speed};
        mac_b    = {17'd0, rspd};
      end
      default: ;
    endcase
  end

  // clamp to +-510.0 and truncate toward zero
  assign acc_neg   = acc[lfps_pkg::ACC_W-1];
  assign acc_mag   = acc_neg ? lfps_pkg::ACC_W'(-acc) : lfps_pkg::ACC_W'(acc);
  assign ctrl_mag  = (acc_mag > lfps_pkg::LIMIT_Q16) ? lfps_pkg::CTRL_LIMIT : acc_mag[24:16];
  assign ctrl_next = acc_neg ? -$signed({1'b0, ctrl_mag}) : $signed({1'b0, ctrl_mag});

  assign sum_wide = {error_sum[lfps_pkg::SUM_W-1], error_sum}
                  + {{(lfps_pkg::SUM_W+1-lfps_pkg::ERR_W){err[lfps_pkg::ERR_W-1]}}, err};
  assign sum_sat  = (sum_wide[lfps_pkg::SUM_W] != sum_wide[lfps_pkg::SUM_W-1])
                  ? (sum_wide[lfps_pkg::SUM_W] ? lfps_pkg::SUM_MIN : lfps_pkg::SUM_MAX)
                  : sum_wide[lfps_pkg::SUM_W-1:0];

  // differential motor mapping
  always_comb begin
    if (ctrl_val > 10'sd0) begin
      if (ctrl_val > 10'sd255) begin
        ldir_next = lfps_pkg::DIR_CW;
        lspd_next = 8'(ctrl_val - 10'sd255);
      end else begin
        ldir_next = lfps_pkg::DIR_CCW;
        lspd_next = 8'(10'sd255 - ctrl_val);
      end
      rdir_next = lfps_pkg::DIR_CW;
      rspd_next = lfps_pkg::FULL_SPEED;
    end else begin
      if (ctrl_val < -10'sd255) begin
        rdir_next = lfps_pkg::DIR_CCW;
        rspd_next = 8'(-(ctrl_val + 10'sd255));
      end else begin
        rdir_next = lfps_pkg::DIR_CW;
        rspd_next = 8'(10'sd255 + ctrl_val);
      end
      ldir_next = lfps_pkg::DIR_CCW;
      lspd_next = lfps_pkg::FULL_SPEED;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lfps_pkg::S_IDLE;
      error_sum     <= '0;
      last_error    <= '0;
      last_position <= lfps_pkg::CENTER_POS;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == lfps_pkg::S_POS) begin
        last_position <= pos_found ? pos_calc : last_position;
      end
      if (state == lfps_pkg::S_CLAMP) begin
        error_sum  <= sum_sat;
        last_error <= err;
      end
      if (state == lfps_pkg::S_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state == lfps_pkg::S_IDLE && s_axis_tvalid) begin
      for (int i = 0; i < lfps_pkg::NUM_SENS; i++) begin
        samples[i] <= s_axis_tdata[i*lfps_pkg::SAMPLE_W +: lfps_pkg::SAMPLE_W];
      end
    end
    if (state == lfps_pkg::S_POS) begin
      found    <= pos_found;
      position <= pos_found ? pos_calc : last_position;
    end
    if (state == lfps_pkg::S_ERR) begin
      err <= $signed({1'b0, target}) - $signed({1'b0, position});
    end
    if (state == lfps_pkg::S_CLAMP) begin
      ctrl_val <= ctrl_next;
    end
    if (state == lfps_pkg::S_MAP) begin
      ldir <= ldir_next;
      rdir <= rdir_next;
      lspd <= lspd_next;
      rspd <= rspd_next;
    end
    if (state == lfps_pkg::S_DUTY_R) begin
      lduty <= lfps_pkg::div255(acc[15:0]);
    end
    if (state == lfps_pkg::S_OUT && out_free) begin
      m_axis_tdata <= {6'd0, ctrl_val, position, found,
                       rduty, rdir, lduty, ldir};
    end
  end

  assign rduty = lfps_pkg::div255(acc[15:0]);

endmodule
`default_nettype wire

// ----- tb/line_follow_pid_steering_unit_tb.sv -----
`timescale 1ns / 100ps
module line_follow_pid_steering_unit_tb;
  import lfps_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 16;

  // indexes past the last register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam sample_t SAMPLE_MAX  = 10'h3FF;
  localparam sample_t JUST_ABOVE  = THRESHOLD_RST + 10'd1;

  typedef struct packed {
    sample_t five;
    sample_t four;
    sample_t three;
    sample_t two;
    sample_t one;
  } sweep_t;

  typedef struct packed {
    logic [CTRL_W-1:0] steer;
    logic [POS_W-1:0]  pos;
    logic              found;
    logic [7:0]        rduty;
    logic [1:0]        rdir;
    logic [7:0]        lduty;
    logic [1:0]        ldir;
  } motor_cmd_t;

  typedef struct {
    sweep_t sweep;
    bit     drain;   // hold until every outstanding result has come back
  } stim_t;

  localparam int IN_PAD = IN_DATA_W - $bits(sweep_t);

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  wire                   s_axis_tready;
  // sample_one, sample_two, sample_three, sample_four, sample_five, pad
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  wire                   m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // left_direction, left_duty, right_direction, right_duty, line_found,
  // position_used, steering_value, pad
  wire [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  wire                   cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  line_follow_pid_steering_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // shadow registers and controller state
  logic [SAMPLE_W-1:0] thr_reg    = THRESHOLD_RST;
  logic [POS_W-1:0]    target_reg = TARGET_RST;
  logic [GAIN_W-1:0]   kp_reg     = KP_RST;
  logic [GAIN_W-1:0]   ki_reg     = KI_RST;
  logic [GAIN_W-1:0]   kd_reg     = KD_RST;
  logic [7:0]          top_reg    = TOP_SPEED_RST;
  int                  sum_acc    = 0;
  int                  prev_err   = 0;
  logic [POS_W-1:0]    held_pos   = CENTER_POS;

  stim_t      pending[$];
  motor_cmd_t expected_cmds[$];
  int         items_queued = 0;
  int         items_sent   = 0;
  int         results_seen = 0;
  int         mismatches   = 0;
  int         send_idle    = 14;
  int         recv_idle    = 71;

  initial forever #1 clk = ~clk;

  function automatic void shadow_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_THRESHOLD: thr_reg    = val[SAMPLE_W-1:0];
      REG_TARGET:    target_reg = val[POS_W-1:0];
      REG_KP:        kp_reg     = val;
      REG_KI:        ki_reg     = val;
      REG_KD:        kd_reg     = val;
      REG_TOP_SPEED: top_reg    = val[7:0];
      default: ;
    endcase
  endfunction

  function automatic motor_cmd_t predict_motor_cmd(input sweep_t sw);
    sample_t    smp [NUM_SENS];
    int         hits, wsum, pos, err, ctrl, lspd, rspd, full;
    longint     pid, lim, nsum;
    motor_cmd_t cmd;
    smp  = '{sw.one, sw.two, sw.three, sw.four, sw.five};
    full = int'(FULL_SPEED);
    hits = 0;
    wsum = 0;
    for (int i = 0; i < NUM_SENS; i++)
      if (smp[i] > thr_reg) begin
        hits++;
        wsum += i + 1;
      end
    pos = (hits != 0) ? wsum * 256 / hits : int'(held_pos);
    err = int'(target_reg) - pos;
    // Q26.16 sum, exact; integral term uses the sum before this step
    pid = longint'(kp_reg) * err + longint'(ki_reg) * sum_acc
        + longint'(kd_reg) * (err - prev_err);
    lim = longint'(CTRL_LIMIT) * 65536;
    if (pid > lim) pid = lim;
    else if (pid < -lim) pid = -lim;
    ctrl = int'((pid < 0 ? -pid : pid) / 65536);
    if (pid < 0) ctrl = -ctrl;
    nsum = longint'(sum_acc) + err;
    if (nsum > SUM_MAX) nsum = SUM_MAX;
    else if (nsum < SUM_MIN) nsum = SUM_MIN;
    sum_acc  = int'(nsum);
    prev_err = err;
    held_pos = pos[POS_W-1:0];
    if (ctrl > 0) begin
      if (ctrl > full) begin
        cmd.ldir = DIR_CW;
        lspd     = ctrl - full;
      end else begin
        cmd.ldir = DIR_CCW;
        lspd     = full - ctrl;
      end
      cmd.rdir = DIR_CW;
      rspd     = full;
    end else begin
      if (ctrl < -full) begin
        cmd.rdir = DIR_CCW;
        rspd     = -ctrl - full;
      end else begin
        cmd.rdir = DIR_CW;
        rspd     = full + ctrl;
      end
      cmd.ldir = DIR_CCW;
      lspd     = full;
    end
    cmd.lduty = 8'(lspd * int'(top_reg) / 255);
    cmd.rduty = 8'(rspd * int'(top_reg) / 255);
    cmd.found = (hits != 0);
    cmd.pos   = held_pos;
    cmd.steer = ctrl[CTRL_W-1:0];
    return cmd;
  endfunction

  function automatic string cmd_text(input motor_cmd_t c);
    return $sformatf("ldir=%0d lduty=%0d rdir=%0d rduty=%0d found=%0b pos=%0d steer=%0d",
                     c.ldir, c.lduty, c.rdir, c.rduty, c.found, c.pos, $signed(c.steer));
  endfunction

  // samples drawn at random above, near and below the threshold so position sets vary
  function automatic sample_t pick_sample(input bit no_line);
    int t, lo, hi;
    t  = int'(thr_reg);
    lo = (t > 0) ? t - 1 : 0;
    hi = (t < 1023) ? t + 1 : 1023;
    if (no_line) return sample_t'($urandom_range(t));
    case ($urandom_range(3))
      0:       return sample_t'($urandom_range(1023));
      1:       return sample_t'($urandom_range(hi, lo));
      2:       return (t < 1023) ? sample_t'($urandom_range(1023, t + 1)) : SAMPLE_MAX;
      default: return sample_t'($urandom_range(t));
    endcase
  endfunction

  task automatic queue_sweep(input sample_t a, b, c, d, e);
    stim_t st;
    st.sweep = '{five: e, four: d, three: c, two: b, one: a};
    st.drain = 1'b0;
    pending.push_back(st);
    items_queued++;
  endtask

  task automatic queue_random(input int n);
    stim_t st;
    bit    dark;
    repeat (n) begin
      dark           = ($urandom_range(9) == 0);
      st.sweep.one   = pick_sample(dark);
      st.sweep.two   = pick_sample(dark);
      st.sweep.three = pick_sample(dark);
      st.sweep.four  = pick_sample(dark);
      st.sweep.five  = pick_sample(dark);
      st.drain       = ($urandom_range(149) == 0);
      pending.push_back(st);
      items_queued++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    shadow_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (items_sent != items_queued || results_seen != items_queued);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input side
  always @(posedge clk) begin : feed
    int    sent_now;
    stim_t nxt;
    sent_now = items_sent;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_cmds.push_back(
          predict_motor_cmd(sweep_t'(s_axis_tdata[$bits(sweep_t)-1:0])));
        sent_now++;
        items_sent <= sent_now;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending.size() != 0 && $urandom_range(99) >= send_idle &&
            (!pending[0].drain || sent_now == results_seen)) begin
          nxt = pending.pop_front();
          s_axis_tdata  <= {{IN_PAD{1'b0}}, nxt.sweep};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk) begin : take
    motor_cmd_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = motor_cmd_t'(m_axis_tdata[$bits(motor_cmd_t)-1:0]);
        results_seen <= results_seen + 1;
        if (expected_cmds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result transfer with nothing expected: %s", cmd_text(got));
        end else begin
          want = expected_cmds.pop_front();
          if (got.ldir !== want.ldir || got.lduty !== want.lduty ||
              got.rdir !== want.rdir || got.rduty !== want.rduty ||
              got.found !== want.found || got.pos !== want.pos ||
              got.steer !== want.steer) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d mismatch\n  exp %s\n  got %s",
                       results_seen, cmd_text(want), cmd_text(got));
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h0000);

    // reset settings: threshold 800, target at center
    queue_sweep(0, 0, 0, 0, 0);                   // dark: center reused
    queue_sweep(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    queue_sweep(SAMPLE_MAX, 0, 0, 0, 0);
    queue_sweep(0, SAMPLE_MAX, 0, 0, 0);
    queue_sweep(0, 0, SAMPLE_MAX, 0, 0);
    queue_sweep(0, 0, 0, SAMPLE_MAX, 0);
    queue_sweep(0, 0, 0, 0, SAMPLE_MAX);
    queue_sweep(0, 0, THRESHOLD_RST, 0, 0);       // at threshold is not a hit
    queue_sweep(0, 0, JUST_ABOVE, 0, 0);
    queue_sweep(JUST_ABOVE, JUST_ABOVE, 0, 0, 0);
    queue_sweep(JUST_ABOVE, JUST_ABOVE, 0, JUST_ABOVE, 0);    // divide by 3
    queue_sweep(JUST_ABOVE, 0, JUST_ABOVE, JUST_ABOVE, 0);
    queue_sweep(0, JUST_ABOVE, JUST_ABOVE, 0, JUST_ABOVE);
    queue_sweep(JUST_ABOVE, JUST_ABOVE, JUST_ABOVE, JUST_ABOVE, 0);
    queue_sweep(0, JUST_ABOVE, JUST_ABOVE, JUST_ABOVE, JUST_ABOVE);
    queue_sweep(JUST_ABOVE, 0, 0, 0, JUST_ABOVE);
    queue_sweep(10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA);
    queue_sweep(10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155);
    queue_sweep(10'h355, 10'h0AA, 10'h355, 10'h0AA, 10'h355);
    queue_random(400);
    wait_drained();

    // gains and speed at their maxima, threshold and target at zero
    send_idle <= 71;
    recv_idle <= 14;
    write_reg(REG_THRESHOLD, 16'd0);
    write_reg(REG_TARGET, 16'd0);
    write_reg(REG_KP, 16'hFFFF);
    write_reg(REG_KI, 16'hFFFF);
    write_reg(REG_KD, 16'hFFFF);
    write_reg(REG_TOP_SPEED, 16'h00FF);
    queue_random(350);
    wait_drained();

    // unity P only: small errors give fractional control that truncates to 0
    write_reg(REG_THRESHOLD, 16'd300);
    write_reg(REG_TARGET, 16'd700);
    write_reg(REG_KP, 16'd256);
    write_reg(REG_KI, 16'd0);
    write_reg(REG_KD, 16'd0);
    write_reg(REG_TOP_SPEED, 16'd0);
    queue_sweep(SAMPLE_MAX, 0, SAMPLE_MAX, SAMPLE_MAX, 0);    // +0.07
    queue_sweep(0, 0, SAMPLE_MAX, 0, 0);                      // -0.27
    queue_random(350);
    wait_drained();

    // random settings, upper data bits exercise the width masks
    send_idle <= 0;
    recv_idle <= 0;
    write_reg(REG_THRESHOLD, 16'($urandom));
    write_reg(REG_TARGET, 16'($urandom));
    write_reg(REG_KP, 16'($urandom));
    write_reg(REG_KI, 16'($urandom));
    write_reg(REG_KD, 16'($urandom));
    write_reg(REG_TOP_SPEED, 16'($urandom));
    queue_random(350);
    wait_drained();

    // integral wind-up: park the line at sensor one, then go dark with the
    // target at the top so the sum keeps climbing, then swing the target down
    write_reg(REG_TARGET, 16'h07FF);
    write_reg(REG_THRESHOLD, 16'd1000);
    write_reg(REG_KP, 16'd0);
    write_reg(REG_KI, 16'd1);
    write_reg(REG_KD, 16'd0);
    queue_sweep(SAMPLE_MAX, 0, 0, 0, 0);
    wait_drained();
    write_reg(REG_THRESHOLD, 16'd1023);     // no sample can exceed this
    queue_random(200);
    wait_drained();
    write_reg(REG_TARGET, 16'd0);
    queue_random(200);
    wait_drained();

    if (mismatches == 0 && expected_cmds.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
